// ===== hw/rtl/htb_pkg.sv =====
// ---------------------------------------------------------------------------
// htb_pkg
// shared widths, datapath operation codes and the command/status structs of
// the huffman tree builder
// ---------------------------------------------------------------------------
package htb_pkg;

    localparam int SYM_W   = 8;
    localparam int ALPHA   = 256;
    localparam int POS_W   = 8;
    localparam int SIZE_W  = POS_W + 1;
    localparam int NODE_W  = 9;
    localparam int KID_W   = 2 * NODE_W;
    localparam int CNT_W   = 32;
    localparam int WGT_W   = 40;
    localparam int OUT_W   = 64;
    localparam int OSH_W   = $clog2(OUT_W);
    localparam int BC_W    = OSH_W + 1;
    localparam int LEAF_W  = SYM_W + 1;
    localparam int PUTN_W  = $clog2(LEAF_W);

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_COUNT,
        OP_PREP,
        OP_SCAN_PREP,
        OP_INIT,
        OP_SCAN,
        OP_COMPACT,
        OP_APPEND,
        OP_ROOT_RD,
        OP_ROOT_PUSH,
        OP_POP_RD,
        OP_POP_WAIT,
        OP_LEAF_LOAD,
        OP_LEAF_PUT,
        OP_INNER_LOAD,
        OP_ZERO_PUT,
        OP_PUSH_R,
        OP_PUSH_L,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic take;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic accept_last;
        logic fsz_zero;
        logic fsz_gt1;
        logic pass_done;
        logic sp_zero;
        logic is_leaf;
        logic put_ok;
        logic put_last;
        logic flush_ok;
    } sts_t;

endpackage

// ===== hw/rtl/htb_in_if.sv =====
// ---------------------------------------------------------------------------
// htb_in_if
// byte channel: one data byte per item with its last flag
// ---------------------------------------------------------------------------
interface htb_in_if;
    logic                     valid;
    logic                     ready;
    logic [htb_pkg::SYM_W-1:0] symbol;
    logic                     last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink (input valid, input symbol, input last, output ready);
endinterface

// ===== hw/rtl/htb_out_if.sv =====
// ---------------------------------------------------------------------------
// htb_out_if
// tree channel: one packed word of the serialised tree per item
// ---------------------------------------------------------------------------
interface htb_out_if;
    logic                     valid;
    logic                     ready;
    logic [htb_pkg::OUT_W-1:0] tree_word;
    logic [htb_pkg::BC_W-1:0]  bit_count;
    logic                     word_last;

    modport source (output valid, output tree_word, output bit_count, output word_last,
                    input ready);
    modport sink (input valid, input tree_word, input bit_count, input word_last,
                  output ready);
endinterface

// ===== hw/rtl/htb_ctrl.sv =====
// ---------------------------------------------------------------------------
// htb_ctrl
// sequencer: clear, count, leaf load, merge loop, preorder walk and flush
// ---------------------------------------------------------------------------
module htb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  htb_pkg::sts_t st,
    output htb_pkg::cmd_t cmd
);

    typedef enum logic [21:0] {
        ST_CLEAR      = 22'h000001,
        ST_COUNT      = 22'h000002,
        ST_LASTWAIT   = 22'h000004,
        ST_INIT_PREP  = 22'h000008,
        ST_INIT       = 22'h000010,
        ST_CHK        = 22'h000020,
        ST_SCAN_PREP  = 22'h000040,
        ST_SCAN       = 22'h000080,
        ST_CMP_PREP   = 22'h000100,
        ST_COMPACT    = 22'h000200,
        ST_APPEND     = 22'h000400,
        ST_ROOT_RD    = 22'h000800,
        ST_ROOT_PUSH  = 22'h001000,
        ST_POP_RD     = 22'h002000,
        ST_POP_WAIT   = 22'h004000,
        ST_LEAF_LOAD  = 22'h008000,
        ST_LEAF_PUT   = 22'h010000,
        ST_INNER_LOAD = 22'h020000,
        ST_ZERO_PUT   = 22'h040000,
        ST_PUSH_R     = 22'h080000,
        ST_PUSH_L     = 22'h100000,
        ST_FLUSH      = 22'h200000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = htb_pkg::OP_IDLE;
        cmd.take   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = htb_pkg::OP_CLEAR;
                if (st.idx_last)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                cmd.op   = htb_pkg::OP_COUNT;
                cmd.take = 1'b1;
                if (st.accept_last)
                begin
                    state_next = ST_LASTWAIT;
                end
            end
            ST_LASTWAIT:
            begin
                state_next = ST_INIT_PREP;
            end
            ST_INIT_PREP:
            begin
                cmd.op = htb_pkg::OP_PREP;
                if (st.fsz_zero)
                begin
                    state_next = ST_COUNT;
                end
                else
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.op = htb_pkg::OP_INIT;
                if (st.pass_done)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (st.fsz_gt1)
                begin
                    state_next = ST_SCAN_PREP;
                end
                else
                begin
                    state_next = ST_ROOT_RD;
                end
            end
            ST_SCAN_PREP:
            begin
                cmd.op     = htb_pkg::OP_SCAN_PREP;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.op = htb_pkg::OP_SCAN;
                if (st.pass_done)
                begin
                    state_next = ST_CMP_PREP;
                end
            end
            ST_CMP_PREP:
            begin
                cmd.op     = htb_pkg::OP_PREP;
                state_next = ST_COMPACT;
            end
            ST_COMPACT:
            begin
                cmd.op = htb_pkg::OP_COMPACT;
                if (st.pass_done)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                cmd.op     = htb_pkg::OP_APPEND;
                state_next = ST_CHK;
            end
            ST_ROOT_RD:
            begin
                cmd.op     = htb_pkg::OP_ROOT_RD;
                state_next = ST_ROOT_PUSH;
            end
            ST_ROOT_PUSH:
            begin
                cmd.op     = htb_pkg::OP_ROOT_PUSH;
                state_next = ST_POP_RD;
            end
            ST_POP_RD:
            begin
                cmd.op = htb_pkg::OP_POP_RD;
                if (st.sp_zero)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                cmd.op = htb_pkg::OP_POP_WAIT;
                if (st.is_leaf)
                begin
                    state_next = ST_LEAF_LOAD;
                end
                else
                begin
                    state_next = ST_INNER_LOAD;
                end
            end
            ST_LEAF_LOAD:
            begin
                cmd.op     = htb_pkg::OP_LEAF_LOAD;
                state_next = ST_LEAF_PUT;
            end
            ST_LEAF_PUT:
            begin
                cmd.op = htb_pkg::OP_LEAF_PUT;
                if (st.put_ok && st.put_last)
                begin
                    state_next = ST_POP_RD;
                end
            end
            ST_INNER_LOAD:
            begin
                cmd.op     = htb_pkg::OP_INNER_LOAD;
                state_next = ST_ZERO_PUT;
            end
            ST_ZERO_PUT:
            begin
                cmd.op = htb_pkg::OP_ZERO_PUT;
                if (st.put_ok)
                begin
                    state_next = ST_PUSH_R;
                end
            end
            ST_PUSH_R:
            begin
                cmd.op     = htb_pkg::OP_PUSH_R;
                state_next = ST_PUSH_L;
            end
            ST_PUSH_L:
            begin
                cmd.op     = htb_pkg::OP_PUSH_L;
                state_next = ST_POP_RD;
            end
            ST_FLUSH:
            begin
                cmd.op = htb_pkg::OP_FLUSH;
                if (st.flush_ok)
                begin
                    state_next = ST_COUNT;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/htb_dpath.sv =====
// ---------------------------------------------------------------------------
// htb_dpath
// histogram, forest and node stores, min-pair scan, walk stack and word packer
// ---------------------------------------------------------------------------
module htb_dpath (
    input  logic          clk,
    input  logic          rst_n,
    input  htb_pkg::cmd_t cmd,
    output htb_pkg::sts_t st,
    htb_in_if.sink        byte_ch,
    htb_out_if.source     tree_ch
);

    localparam int DEPTH = htb_pkg::ALPHA;

    // stores
    logic [htb_pkg::CNT_W-1:0]  cnt_mem  [0:DEPTH-1];
    logic [htb_pkg::SYM_W-1:0]  seen_mem [0:DEPTH-1];
    logic [htb_pkg::WGT_W-1:0]  flw_mem  [0:DEPTH-1];
    logic [htb_pkg::NODE_W-1:0] fln_mem  [0:DEPTH-1];
    logic [htb_pkg::KID_W-1:0]  kid_mem  [0:DEPTH-1];
    logic [htb_pkg::NODE_W-1:0] stk_mem  [0:DEPTH-1];

    logic [htb_pkg::CNT_W-1:0]  cnt_q_reg;
    logic [htb_pkg::SYM_W-1:0]  seen_q_reg;
    logic [htb_pkg::WGT_W-1:0]  flw_q_reg;
    logic [htb_pkg::NODE_W-1:0] fln_q_reg;
    logic [htb_pkg::KID_W-1:0]  kid_q_reg;
    logic [htb_pkg::NODE_W-1:0] stk_q_reg;

    // control registers
    logic                       s1_v_reg;
    logic                       fw_v_reg;
    logic [htb_pkg::SIZE_W-1:0] fsz_reg;
    logic [htb_pkg::SIZE_W-1:0] idx_reg;
    logic [htb_pkg::SIZE_W-1:0] wpos_reg;
    logic [htb_pkg::POS_W-1:0]  inner_reg;
    logic                       a_v_reg;
    logic                       b_v_reg;
    logic                       m1_v_reg;
    logic                       m2_v_reg;
    logic [htb_pkg::SIZE_W-1:0] sp_reg;
    logic [htb_pkg::PUTN_W-1:0] put_n_reg;
    logic [htb_pkg::BC_W-1:0]   ecnt_reg;
    logic                       ov_reg;

    // payload registers
    logic [htb_pkg::SYM_W-1:0]  s1_sym_reg;
    logic [htb_pkg::SYM_W-1:0]  fw_addr_reg;
    logic [htb_pkg::CNT_W-1:0]  fw_val_reg;
    logic [htb_pkg::POS_W-1:0]  a_pos_reg;
    logic [htb_pkg::POS_W-1:0]  b_pos_reg;
    logic [htb_pkg::SYM_W-1:0]  b_sym_reg;
    logic [htb_pkg::WGT_W-1:0]  m1_w_reg;
    logic [htb_pkg::POS_W-1:0]  m1_i_reg;
    logic [htb_pkg::NODE_W-1:0] m1_n_reg;
    logic [htb_pkg::WGT_W-1:0]  m2_w_reg;
    logic [htb_pkg::POS_W-1:0]  m2_i_reg;
    logic [htb_pkg::NODE_W-1:0] m2_n_reg;
    logic [htb_pkg::KID_W-1:0]  kid_reg;
    logic [htb_pkg::LEAF_W-1:0] leaf_reg;
    logic [htb_pkg::OUT_W-1:0]  ebuf_reg;
    logic [htb_pkg::OUT_W-1:0]  ow_reg;
    logic [htb_pkg::BC_W-1:0]   obc_reg;
    logic                       olast_reg;

    // combinational
    logic                       accept;
    logic                       pass_op;
    logic                       issue;
    logic [htb_pkg::CNT_W-1:0]  old_cnt;
    logic [htb_pkg::CNT_W-1:0]  new_cnt;
    logic                       is_new;
    logic                       keep;

    logic [htb_pkg::POS_W-1:0]  cnt_raddr;
    logic                       cnt_we;
    logic [htb_pkg::POS_W-1:0]  cnt_waddr;
    logic [htb_pkg::CNT_W-1:0]  cnt_wdata;
    logic [htb_pkg::POS_W-1:0]  seen_raddr;
    logic [htb_pkg::POS_W-1:0]  fl_raddr;
    logic                       fl_we;
    logic [htb_pkg::POS_W-1:0]  fl_waddr;
    logic [htb_pkg::WGT_W-1:0]  flw_wdata;
    logic [htb_pkg::NODE_W-1:0] fln_wdata;
    logic                       stk_we;
    logic [htb_pkg::POS_W-1:0]  stk_waddr;
    logic [htb_pkg::NODE_W-1:0] stk_wdata;
    logic [htb_pkg::SIZE_W-1:0] sp_dec;

    logic                       put;
    logic                       put_bit;
    logic                       full;
    logic                       ofree;
    logic                       xfer;
    logic                       flush;
    logic [htb_pkg::OSH_W-1:0]  bit_sh;

    assign accept   = byte_ch.valid && byte_ch.ready;
    assign byte_ch.ready = cmd.take;

    assign pass_op = (cmd.op == htb_pkg::OP_INIT) || (cmd.op == htb_pkg::OP_SCAN)
                  || (cmd.op == htb_pkg::OP_COMPACT);
    assign issue   = pass_op && (idx_reg < fsz_reg);

    // histogram update with forwarding of the previous write
    assign old_cnt = (fw_v_reg && (fw_addr_reg == s1_sym_reg)) ? fw_val_reg : cnt_q_reg;
    assign new_cnt = (&old_cnt) ? old_cnt : old_cnt + 1'b1;
    assign is_new  = (old_cnt == '0);

    assign keep    = (a_pos_reg != m1_i_reg) && (a_pos_reg != m2_i_reg);
    assign sp_dec  = sp_reg - 1'b1;

    assign cnt_raddr  = (cmd.op == htb_pkg::OP_COUNT) ? byte_ch.symbol : seen_q_reg;
    assign seen_raddr = (cmd.op == htb_pkg::OP_POP_WAIT) ? stk_q_reg[htb_pkg::POS_W-1:0]
                                                         : idx_reg[htb_pkg::POS_W-1:0];
    assign fl_raddr   = (cmd.op == htb_pkg::OP_ROOT_RD) ? '0 : idx_reg[htb_pkg::POS_W-1:0];

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = s1_sym_reg;
        cnt_wdata = new_cnt;
        if (s1_v_reg)
        begin
            cnt_we = 1'b1;
        end
        else if (cmd.op == htb_pkg::OP_CLEAR)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = idx_reg[htb_pkg::POS_W-1:0];
            cnt_wdata = '0;
        end
        else if ((cmd.op == htb_pkg::OP_INIT) && b_v_reg)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = b_sym_reg;
            cnt_wdata = '0;
        end
    end

    always_comb
    begin
        fl_we     = 1'b0;
        fl_waddr  = wpos_reg[htb_pkg::POS_W-1:0];
        flw_wdata = flw_q_reg;
        fln_wdata = fln_q_reg;
        case (cmd.op)
            htb_pkg::OP_INIT:
            begin
                fl_we     = b_v_reg;
                fl_waddr  = b_pos_reg;
                flw_wdata = htb_pkg::WGT_W'(cnt_q_reg);
                fln_wdata = htb_pkg::NODE_W'(b_pos_reg);
            end
            htb_pkg::OP_COMPACT:
            begin
                fl_we = a_v_reg && keep;
            end
            htb_pkg::OP_APPEND:
            begin
                fl_we     = 1'b1;
                flw_wdata = m1_w_reg + m2_w_reg;
                fln_wdata = {1'b1, inner_reg};
            end
            default:
            begin
                fl_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = sp_reg[htb_pkg::POS_W-1:0];
        stk_wdata = kid_reg[htb_pkg::NODE_W-1:0];
        case (cmd.op)
            htb_pkg::OP_ROOT_PUSH:
            begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = fln_q_reg;
            end
            htb_pkg::OP_PUSH_R:
            begin
                stk_we = 1'b1;
            end
            htb_pkg::OP_PUSH_L:
            begin
                stk_we    = 1'b1;
                stk_wdata = kid_reg[htb_pkg::KID_W-1:htb_pkg::NODE_W];
            end
            default:
            begin
                stk_we = 1'b0;
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg && is_new)
        begin
            seen_mem[fsz_reg[htb_pkg::POS_W-1:0]] <= s1_sym_reg;
        end
        seen_q_reg <= seen_mem[seen_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fl_we)
        begin
            flw_mem[fl_waddr] <= flw_wdata;
            fln_mem[fl_waddr] <= fln_wdata;
        end
        flw_q_reg <= flw_mem[fl_raddr];
        fln_q_reg <= fln_mem[fl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == htb_pkg::OP_APPEND)
        begin
            kid_mem[inner_reg] <= {m1_n_reg, m2_n_reg};
        end
        kid_q_reg <= kid_mem[stk_q_reg[htb_pkg::POS_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_q_reg <= stk_mem[sp_dec[htb_pkg::POS_W-1:0]];
    end

    // word packer
    assign put     = (cmd.op == htb_pkg::OP_LEAF_PUT) || (cmd.op == htb_pkg::OP_ZERO_PUT);
    assign put_bit = (cmd.op == htb_pkg::OP_LEAF_PUT) && leaf_reg[htb_pkg::LEAF_W-1];
    assign flush   = (cmd.op == htb_pkg::OP_FLUSH);
    assign full    = (ecnt_reg == htb_pkg::BC_W'(htb_pkg::OUT_W));
    assign ofree   = !ov_reg || tree_ch.ready;
    assign xfer    = ofree && (flush || (put && full));
    assign bit_sh  = htb_pkg::OSH_W'(htb_pkg::OUT_W - 1) - ecnt_reg[htb_pkg::OSH_W-1:0];

    assign tree_ch.valid     = ov_reg;
    assign tree_ch.tree_word = ow_reg;
    assign tree_ch.bit_count = obc_reg;
    assign tree_ch.word_last = olast_reg;

    // status
    assign st.idx_last    = (idx_reg == htb_pkg::SIZE_W'(DEPTH - 1));
    assign st.accept_last = accept && byte_ch.last;
    assign st.fsz_zero    = (fsz_reg == '0);
    assign st.fsz_gt1     = (fsz_reg > htb_pkg::SIZE_W'(1));
    assign st.pass_done   = !issue && !a_v_reg && !b_v_reg;
    assign st.sp_zero     = (sp_reg == '0);
    assign st.is_leaf     = !stk_q_reg[htb_pkg::NODE_W-1];
    assign st.put_ok      = put && (!full || ofree);
    assign st.put_last    = (put_n_reg == htb_pkg::PUTN_W'(htb_pkg::LEAF_W - 1));
    assign st.flush_ok    = flush && ofree;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            fw_v_reg  <= 1'b0;
            fsz_reg   <= '0;
            idx_reg   <= '0;
            wpos_reg  <= '0;
            inner_reg <= '0;
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            m1_v_reg  <= 1'b0;
            m2_v_reg  <= 1'b0;
            sp_reg    <= '0;
            put_n_reg <= '0;
            ecnt_reg  <= '0;
            ebuf_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            fw_v_reg <= s1_v_reg;
            a_v_reg  <= issue;
            b_v_reg  <= a_v_reg && (cmd.op == htb_pkg::OP_INIT);

            if (st.flush_ok)
            begin
                fsz_reg <= '0;
            end
            else if (s1_v_reg && is_new)
            begin
                fsz_reg <= fsz_reg + 1'b1;
            end
            else if (cmd.op == htb_pkg::OP_APPEND)
            begin
                fsz_reg <= wpos_reg + 1'b1;
            end

            if ((cmd.op == htb_pkg::OP_PREP) || (cmd.op == htb_pkg::OP_SCAN_PREP))
            begin
                idx_reg  <= '0;
                wpos_reg <= '0;
            end
            else
            begin
                if ((cmd.op == htb_pkg::OP_CLEAR) || issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if ((cmd.op == htb_pkg::OP_COMPACT) && a_v_reg && keep)
                begin
                    wpos_reg <= wpos_reg + 1'b1;
                end
            end

            if (st.flush_ok)
            begin
                inner_reg <= '0;
            end
            else if (cmd.op == htb_pkg::OP_APPEND)
            begin
                inner_reg <= inner_reg + 1'b1;
            end

            if (cmd.op == htb_pkg::OP_SCAN_PREP)
            begin
                m1_v_reg <= 1'b0;
                m2_v_reg <= 1'b0;
            end
            else if ((cmd.op == htb_pkg::OP_SCAN) && a_v_reg)
            begin
                if (!m1_v_reg || (flw_q_reg < m1_w_reg))
                begin
                    m1_v_reg <= 1'b1;
                    m2_v_reg <= m1_v_reg;
                end
                else if (!m2_v_reg || (flw_q_reg < m2_w_reg))
                begin
                    m2_v_reg <= 1'b1;
                end
            end

            case (cmd.op)
                htb_pkg::OP_ROOT_PUSH:
                begin
                    sp_reg <= htb_pkg::SIZE_W'(1);
                end
                htb_pkg::OP_POP_RD:
                begin
                    if (!st.sp_zero)
                    begin
                        sp_reg <= sp_dec;
                    end
                end
                htb_pkg::OP_PUSH_R, htb_pkg::OP_PUSH_L:
                begin
                    sp_reg <= sp_reg + 1'b1;
                end
                default:
                begin
                    sp_reg <= sp_reg;
                end
            endcase

            if (cmd.op == htb_pkg::OP_LEAF_LOAD)
            begin
                put_n_reg <= '0;
            end
            else if ((cmd.op == htb_pkg::OP_LEAF_PUT) && st.put_ok)
            begin
                put_n_reg <= put_n_reg + 1'b1;
            end

            if (xfer)
            begin
                ov_reg <= 1'b1;
            end
            else if (tree_ch.ready)
            begin
                ov_reg <= 1'b0;
            end

            if (xfer)
            begin
                ecnt_reg <= put ? htb_pkg::BC_W'(1) : '0;
                ebuf_reg <= {put_bit, {(htb_pkg::OUT_W - 1){1'b0}}};
            end
            else if (put && !full)
            begin
                ecnt_reg <= ecnt_reg + 1'b1;
                ebuf_reg <= ebuf_reg | (htb_pkg::OUT_W'(put_bit) << bit_sh);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sym_reg  <= byte_ch.symbol;
        fw_addr_reg <= s1_sym_reg;
        fw_val_reg  <= new_cnt;
        a_pos_reg   <= idx_reg[htb_pkg::POS_W-1:0];
        b_pos_reg   <= a_pos_reg;
        b_sym_reg   <= seen_q_reg;

        if ((cmd.op == htb_pkg::OP_SCAN) && a_v_reg)
        begin
            if (!m1_v_reg || (flw_q_reg < m1_w_reg))
            begin
                m2_w_reg <= m1_w_reg;
                m2_i_reg <= m1_i_reg;
                m2_n_reg <= m1_n_reg;
                m1_w_reg <= flw_q_reg;
                m1_i_reg <= a_pos_reg;
                m1_n_reg <= fln_q_reg;
            end
            else if (!m2_v_reg || (flw_q_reg < m2_w_reg))
            begin
                m2_w_reg <= flw_q_reg;
                m2_i_reg <= a_pos_reg;
                m2_n_reg <= fln_q_reg;
            end
        end

        if (cmd.op == htb_pkg::OP_INNER_LOAD)
        begin
            kid_reg <= kid_q_reg;
        end

        if (cmd.op == htb_pkg::OP_LEAF_LOAD)
        begin
            leaf_reg <= {1'b1, seen_q_reg};
        end
        else if ((cmd.op == htb_pkg::OP_LEAF_PUT) && st.put_ok)
        begin
            leaf_reg <= {leaf_reg[htb_pkg::LEAF_W-2:0], 1'b0};
        end

        if (xfer)
        begin
            ow_reg    <= ebuf_reg;
            obc_reg   <= ecnt_reg;
            olast_reg <= flush;
        end
    end

endmodule

// ===== hw/rtl/huffman_tree_builder_top.sv =====
// ---------------------------------------------------------------------------
// huffman_tree_builder_top
// counts a byte stream and, on the last byte, builds the huffman tree and
// sends it out in preorder, packed msb first into 64-bit words
// ---------------------------------------------------------------------------
// While counting, one byte item is taken every clock. After reset a clearing
// pass runs through the histogram memory with ready low. Once the last byte
// is taken, ready stays low until the final word is in the output register:
// the n leaves are loaded into the forest, each merge rescans and then
// compacts the forest through the forest memory, which has one read and one
// write port, and the walk then emits each tree bit, using the stack memory
// for every leaf and inner node, with the root read and the final flush
// around it; a stall on the tree channel holds the walk.
module huffman_tree_builder_top (
    input  logic      clk,
    input  logic      rst_n,
    htb_in_if.sink    byte_ch,
    htb_out_if.source tree_ch
);

    htb_pkg::cmd_t cmd;
    htb_pkg::sts_t st;

    htb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    htb_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .st      (st),
        .byte_ch (byte_ch),
        .tree_ch (tree_ch)
    );

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        byte_ch.valid && byte_ch.ready && byte_ch.last |=> !byte_ch.ready)
        else $error("byte channel still open after last item");

    a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
        tree_ch.valid && !tree_ch.word_last |-> tree_ch.bit_count == 7'd64)
        else $error("partial word before end of tree");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        tree_ch.valid |-> (tree_ch.bit_count != 7'd0) && (tree_ch.bit_count <= 7'd64))
        else $error("bit count out of range");

    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        tree_ch.valid && !tree_ch.word_last |-> !byte_ch.ready)
        else $error("byte channel open during tree output");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the huffman tree builder: byte data sets go in
// through a queue-fed driver, a local tree builder predicts every packed word
// of the preorder tree, and a monitor compares each word as it leaves
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [htb_pkg::SYM_W-1:0] sym;
        logic                      last;
    } byte_item_t;

    typedef struct {
        logic [htb_pkg::OUT_W-1:0] word;
        logic [htb_pkg::BC_W-1:0]  nbits;
        logic                      wlast;
    } tree_word_t;

    logic clk;
    logic rst_n;

    htb_in_if  byte_ch ();
    htb_out_if tree_ch ();

    huffman_tree_builder_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .tree_ch (tree_ch)
    );

    byte_item_t  pending_bytes[$];
    tree_word_t  tree_words_due[$];
    int unsigned hist[htb_pkg::ALPHA];
    logic [htb_pkg::SYM_W-1:0] seen_syms[htb_pkg::ALPHA];
    int          n_seen;
    int          errs;
    int          in_gap;
    int          out_gap;
    int          hold_left;
    bit          hold_req;
    bit          hold_done;
    bit          quiet;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n          = 1'b0;
        byte_ch.valid  = 1'b0;
        byte_ch.symbol = '0;
        byte_ch.last   = 1'b0;
        tree_ch.ready  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // count one byte; on last build the tree and queue its words
    task automatic tally(input logic [htb_pkg::SYM_W-1:0] s, input logic lst);
        longint unsigned wt[512];
        int fl[htb_pkg::ALPHA];
        int kid_l[htb_pkg::ALPHA];
        int kid_r[htb_pkg::ALPHA];
        int stk[$];
        bit bits[$];
        int fs, inner, a, b, w, lo, hi, nn, n;
        logic [htb_pkg::OUT_W-1:0] acc;
        int nb;
        tree_word_t t;
        if (hist[s] == 0)
        begin
            seen_syms[n_seen] = s;
            n_seen++;
        end
        if (hist[s] != 32'hFFFF_FFFF)
            hist[s]++;
        if (!lst)
            return;
        fs = n_seen;
        for (int k = 0; k < fs; k++)
        begin
            fl[k] = k;
            wt[k] = hist[seen_syms[k]];
        end
        inner = 0;
        while (fs > 1)
        begin
            a = 0;
            for (int i = 1; i < fs; i++)
                if (wt[fl[i]] < wt[fl[a]])
                    a = i;
            b = (a == 0) ? 1 : 0;
            for (int i = 0; i < fs; i++)
                if (i != a && wt[fl[i]] < wt[fl[b]])
                    b = i;
            nn = htb_pkg::ALPHA + inner;
            wt[nn] = wt[fl[a]] + wt[fl[b]];
            kid_l[inner] = fl[a];
            kid_r[inner] = fl[b];
            inner++;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            w = 0;
            for (int j = 0; j < fs; j++)
                if (j != lo && j != hi)
                begin
                    fl[w] = fl[j];
                    w++;
                end
            fl[w] = nn;
            fs = w + 1;
        end
        stk = {stk, fl[0]};
        while (stk.size() > 0)
        begin
            n = stk.pop_back();
            if (n < htb_pkg::ALPHA)
            begin
                bits = {bits, 1'b1};
                for (int i = htb_pkg::SYM_W - 1; i >= 0; i--)
                    bits = {bits, seen_syms[n][i]};
            end
            else
            begin
                bits = {bits, 1'b0};
                stk = {stk, kid_r[n - htb_pkg::ALPHA]};
                stk = {stk, kid_l[n - htb_pkg::ALPHA]};
            end
        end
        acc = '0;
        nb = 0;
        foreach (bits[i])
        begin
            acc[htb_pkg::OUT_W - 1 - nb] = bits[i];
            nb++;
            if (nb == htb_pkg::OUT_W)
            begin
                t.word = acc;
                t.nbits = htb_pkg::BC_W'(nb);
                t.wlast = 1'b0;
                tree_words_due = {tree_words_due, t};
                acc = '0;
                nb = 0;
            end
        end
        if (nb != 0)
        begin
            t.word = acc;
            t.nbits = htb_pkg::BC_W'(nb);
            t.wlast = 1'b0;
            tree_words_due = {tree_words_due, t};
        end
        tree_words_due[tree_words_due.size() - 1].wlast = 1'b1;
        for (int k = 0; k < htb_pkg::ALPHA; k++)
            hist[k] = 0;
        n_seen = 0;
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        byte_item_t it;
        bit nv;
        if (!rst_n)
        begin
            byte_ch.valid  <= 1'b0;
            byte_ch.symbol <= '0;
            byte_ch.last   <= 1'b0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                tally(byte_ch.symbol, byte_ch.last);
            if (!byte_ch.valid || byte_ch.ready)
            begin
                nv = 1'b0;
                if (in_gap > 0)
                    in_gap--;
                else if (!quiet && pending_bytes.size() > 0 && $urandom_range(0, 7) == 0)
                    in_gap = $urandom_range(0, 8);
                else if (pending_bytes.size() > 0)
                begin
                    it = pending_bytes.pop_front();
                    nv = 1'b1;
                    byte_ch.symbol <= it.sym;
                    byte_ch.last   <= it.last;
                end
                byte_ch.valid <= nv;
            end
        end
    end

    // long receiver hold-off, started once the tree output begins
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req && !hold_done && tree_ch.valid)
        begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // tree word monitor
    always @(posedge clk or negedge rst_n)
    begin
        tree_word_t t;
        bit nr;
        if (!rst_n)
            tree_ch.ready <= 1'b0;
        else
        begin
            if (tree_ch.valid && tree_ch.ready)
            begin
                if (tree_words_due.size() == 0)
                begin
                    $error("unexpected tree word %h", tree_ch.tree_word);
                    errs++;
                end
                else
                begin
                    t = tree_words_due.pop_front();
                    if (tree_ch.tree_word !== t.word)
                    begin
                        $error("tree_word exp %h got %h", t.word, tree_ch.tree_word);
                        errs++;
                    end
                    if (tree_ch.bit_count !== t.nbits)
                    begin
                        $error("bit_count exp %0d got %0d", t.nbits, tree_ch.bit_count);
                        errs++;
                    end
                    if (tree_ch.word_last !== t.wlast)
                    begin
                        $error("word_last exp %0d got %0d", t.wlast, tree_ch.word_last);
                        errs++;
                    end
                end
            end
            nr = 1'b1;
            if (hold_left > 0)
                nr = 1'b0;
            else if (out_gap > 0)
            begin
                out_gap--;
                nr = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_gap = $urandom_range(0, 8);
                nr = 1'b0;
            end
            tree_ch.ready <= nr;
        end
    end

    task automatic add_byte(input logic [htb_pkg::SYM_W-1:0] s, input logic lst);
        byte_item_t it;
        it.sym = s;
        it.last = lst;
        pending_bytes = {pending_bytes, it};
    endtask

    task automatic add_set(input int len, input int base, input int span);
        int skew;
        skew = $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            if (skew)
                add_byte(htb_pkg::SYM_W'(base + $urandom_range(0, $urandom_range(0, span))),
                         i == len - 1);
            else
                add_byte(htb_pkg::SYM_W'(base + $urandom_range(0, span)), i == len - 1);
        end
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || byte_ch.valid || tree_words_due.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int perm[htb_pkg::ALPHA];
        int j, tmp, sent, len;
        errs = 0;
        n_seen = 0;
        in_gap = 0;
        out_gap = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        quiet = 1'b0;
        for (int k = 0; k < htb_pkg::ALPHA; k++)
            hist[k] = 0;

        // single leaf, both extremes, repeats and ties
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h55, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h0F, 1'b0);
        add_byte(8'hF0, 1'b1);
        add_byte(8'h11, 1'b0);
        add_byte(8'h11, 1'b0);
        add_byte(8'h11, 1'b0);
        add_byte(8'h11, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h03, 1'b0);
        add_byte(8'h03, 1'b0);
        add_byte(8'h03, 1'b0);
        add_byte(8'h04, 1'b0);
        add_byte(8'h01, 1'b1);
        sent = 21;
        drain();

        // every symbol, shuffled, with extra repeats; the receiver then holds off
        for (int k = 0; k < htb_pkg::ALPHA; k++)
            perm[k] = k;
        for (int k = htb_pkg::ALPHA - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        for (int k = 0; k < htb_pkg::ALPHA; k++)
            add_byte(htb_pkg::SYM_W'(perm[k]), 1'b0);
        for (int k = 0; k < 39; k++)
            add_byte(htb_pkg::SYM_W'($urandom_range(0, 255)), 1'b0);
        add_byte(htb_pkg::SYM_W'($urandom_range(0, 255)), 1'b1);
        sent += 296;
        add_set(12, $urandom_range(0, 240), 15);
        add_set(8, $urandom_range(0, 250), 5);
        sent += 20;
        hold_req = 1'b1;
        drain();

        while (sent < 380)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
            add_set(len, $urandom_range(0, 200), $urandom_range(0, 55));
            sent += len;
        end
        drain();

        quiet = 1'b1;
        while (sent < 410)
        begin
            len = $urandom_range(1, 10);
            add_set(len, $urandom_range(0, 250), 5);
            sent += len;
        end
        drain();
        repeat (50) @(posedge clk);

        if (errs == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
